[src/jfv_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// jfv_pkg - shared types and constants for the jump flooding Voronoi engine
// Command codes, site map entry layout and configuration register indexes.
// ============================================================================
package jfv_pkg;

    localparam int COORD_W = 8;   // site coordinate width
    localparam int REG_W   = 9;   // configuration register width

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [REG_W-1:0] DIM_RESET = 9'd256;

    // one site map entry: valid flag and coordinates of the nearest site
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_site;

endpackage

[src/jfv_site_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// jfv_site_ram - site map storage
// One write port, one read port with registered read data.
// ============================================================================
module jfv_site_ram #(
    parameter int AW = 16
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  jfv_pkg::t_site i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr,
    output jfv_pkg::t_site o_rdata
);

    jfv_pkg::t_site mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

[src/jump_flood_voronoi.sv]
`timescale 1ns / 1ps
// ============================================================================
// jump_flood_voronoi - jump flooding Voronoi engine
// Holds a frame of site flags, floods nearest-site labels in place on a
// start request and returns one pixel's nearest site on a read request.
// ============================================================================
//
//  channel   | direction | tuser               | tdata (lowest bit up)
//  ----------+-----------+---------------------+------------------------------
//  s_axis    | in        | command [1:0]       | pixel_x[7:0], pixel_y[15:8],
//            |           |                     | is_site[16], zero pad [23:17]
//  m_axis    | out       | found [0]           | site_x[7:0], site_y[15:8]
//  cfg       | in        | -                   | i_cfg_addr 0 width, 1 height
//
//  Load and read requests can be accepted back to back; the RAM read is
//  issued at the accepting edge and a read result passes from the RAM read
//  register into the output register. A start request holds s_axis_tready
//  low for the whole flood. Each pixel costs a write state plus, per
//  neighbour, an address state when it falls outside the frame, an address
//  and a read state when it holds no site, and when it does also two passes
//  through the shared squarer. Flood passes = floor(log2(max(w,h))).
//  Reset is synchronous and active low; the site map is not cleared, so
//  every pixel in use must be loaded before start.
//  A read result that cannot leave waits in a one-entry holding stage;
//  outside floods, input stalls only while it is full and output is stalled.
// ============================================================================
module jump_flood_voronoi #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y, is_site
    input  logic [1:0]  s_axis_tuser,   // command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // site_x, site_y
    output logic [0:0]  m_axis_tuser,   // found
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata
);

    localparam int CRD = jfv_pkg::COORD_W;
    localparam int XW  = $clog2(MAX_WIDTH);        // column index bits
    localparam int YW  = $clog2(MAX_HEIGHT);       // row index bits
    localparam int XCW = $clog2(MAX_WIDTH + 1);    // column count bits
    localparam int YCW = $clog2(MAX_HEIGHT + 1);   // row count bits
    localparam int CW  = (XCW > YCW) ? XCW : YCW;  // step width
    localparam int EW  = CW + 1;                   // neighbour coordinate math
    localparam int IW  = (EW > CRD + 1) ? EW : CRD + 1;
    localparam int MW  = (XW > YW) ? XW : YW;
    localparam int DW  = (MW > CRD) ? MW : CRD;    // distance component
    localparam int SQW = 2 * DW;
    localparam int BDW = SQW + 1;                  // squared distance
    localparam int AW  = XW + YW;

    localparam logic [1:0] NB_LO  = 2'd0;
    localparam logic [1:0] NB_MID = 2'd1;
    localparam logic [1:0] NB_HI  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_SQX,
        S_SQY,
        S_WRITE
    } t_state;

    // ---------------------------------------------------------------- regs
    t_state            r_state,     n_state;
    logic [8:0]        r_width,     r_height;
    logic [CW-1:0]     r_step,      n_step;
    logic [XW-1:0]     r_col,       n_col;
    logic [YW-1:0]     r_row,       n_row;
    logic [1:0]        r_nbx,       n_nbx;
    logic [1:0]        r_nby,       n_nby;
    logic              r_have,      n_have;
    logic [BDW-1:0]    r_best_dist, n_best_dist;
    jfv_pkg::t_site    r_best_site, n_best_site;
    logic [DW-1:0]     r_dx,        n_dx;
    logic [DW-1:0]     r_dy,        n_dy;
    logic [SQW-1:0]    r_acc,       n_acc;
    logic              r_resp_pend, n_resp_pend;
    logic              r_rd_inside, n_rd_inside;
    logic              r_m_valid,   n_m_valid;
    logic              r_m_found,   n_m_found;
    logic [CRD-1:0]    r_m_x,       n_m_x;
    logic [CRD-1:0]    r_m_y,       n_m_y;

    // ------------------------------------------------------------ wiring
    logic              s_acc;
    jfv_pkg::t_cmd     cmd;
    logic [CRD-1:0]    px, py;
    logic              flag;
    logic [XCW-1:0]    w_eff;
    logic [YCW-1:0]    h_eff;
    logic [CW-1:0]     dim_max;
    logic              in_frame;
    logic              moving;

    logic [EW-1:0]     nx, ny;
    logic              nx_ok, ny_ok;
    logic              nb_last;
    logic              col_last, row_last;
    logic [CW-1:0]     step_half;

    logic [DW-1:0]     mul_a;
    logic [SQW-1:0]    sq;
    logic [BDW-1:0]    nb_dist;
    logic [DW-1:0]     col_d, row_d, sx_d, sy_d;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    jfv_pkg::t_site    ram_wdata, ram_rdata;
    logic              rd_found;

    assign cmd  = jfv_pkg::t_cmd'(s_axis_tuser);
    assign px   = s_axis_tdata[7:0];
    assign py   = s_axis_tdata[15:8];
    assign flag = s_axis_tdata[16];

    // zero counts as 1, anything above the maximum clamps to it
    assign w_eff = (r_width == '0) ? XCW'(1)
                 : (int'(r_width) > MAX_WIDTH) ? XCW'(MAX_WIDTH) : XCW'(r_width);
    assign h_eff = (r_height == '0) ? YCW'(1)
                 : (int'(r_height) > MAX_HEIGHT) ? YCW'(MAX_HEIGHT) : YCW'(r_height);
    assign dim_max = (CW'(w_eff) > CW'(h_eff)) ? CW'(w_eff) : CW'(h_eff);

    assign in_frame = (IW'(px) < IW'(w_eff)) && (IW'(py) < IW'(h_eff));

    // a held read result moves to the output register this cycle
    assign moving = r_resp_pend && (!r_m_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE) && (!r_resp_pend || moving);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // neighbour coordinates at -step, 0, +step
    always_comb begin
        case (r_nby)
            NB_LO: begin
                ny    = EW'(r_row) - EW'(r_step);
                ny_ok = EW'(r_row) >= EW'(r_step);
            end
            NB_MID: begin
                ny    = EW'(r_row);
                ny_ok = 1'b1;
            end
            NB_HI: begin
                ny    = EW'(r_row) + EW'(r_step);
                ny_ok = (EW'(r_row) + EW'(r_step)) < EW'(h_eff);
            end
            default: begin
                ny    = '0;
                ny_ok = 1'b0;
            end
        endcase
        case (r_nbx)
            NB_LO: begin
                nx    = EW'(r_col) - EW'(r_step);
                nx_ok = EW'(r_col) >= EW'(r_step);
            end
            NB_MID: begin
                nx    = EW'(r_col);
                nx_ok = 1'b1;
            end
            NB_HI: begin
                nx    = EW'(r_col) + EW'(r_step);
                nx_ok = (EW'(r_col) + EW'(r_step)) < EW'(w_eff);
            end
            default: begin
                nx    = '0;
                nx_ok = 1'b0;
            end
        endcase
    end

    assign nb_last   = (r_nbx == NB_HI) && (r_nby == NB_HI);
    assign col_last  = (XCW'(r_col) + XCW'(1)) == w_eff;
    assign row_last  = (YCW'(r_row) + YCW'(1)) == h_eff;
    assign step_half = r_step >> 1;

    // shared squarer: |dx| in S_SQX, |dy| in S_SQY
    assign mul_a   = (r_state == S_SQX) ? r_dx : r_dy;
    assign sq      = SQW'(mul_a) * SQW'(mul_a);
    assign nb_dist = BDW'(r_acc) + BDW'(sq);

    assign col_d = DW'(r_col);
    assign row_d = DW'(r_row);
    assign sx_d  = DW'(ram_rdata.x);
    assign sy_d  = DW'(ram_rdata.y);

    // ------------------------------------------------------------ RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {YW'(py), XW'(px)};
        ram_wdata = flag ? jfv_pkg::t_site'{valid: 1'b1, x: px, y: py} : '0;
        ram_re    = 1'b0;
        ram_raddr = {YW'(py), XW'(px)};
        case (r_state)
            S_IDLE: begin
                ram_we = s_acc && (cmd == jfv_pkg::CMD_LOAD) && in_frame;
                ram_re = s_acc && (cmd == jfv_pkg::CMD_READ);
            end
            S_ADDR: begin
                ram_re    = nx_ok && ny_ok;
                ram_raddr = {ny[YW-1:0], nx[XW-1:0]};
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = {r_row, r_col};
                ram_wdata = r_have ? r_best_site : '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    jfv_site_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_found = r_rd_inside && ram_rdata.valid;

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_col       = r_col;
        n_row       = r_row;
        n_nbx       = r_nbx;
        n_nby       = r_nby;
        n_have      = r_have;
        n_best_dist = r_best_dist;
        n_best_site = r_best_site;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_acc       = r_acc;
        n_resp_pend = r_resp_pend && !moving;
        n_rd_inside = r_rd_inside;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_found   = r_m_found;
        n_m_x       = r_m_x;
        n_m_y       = r_m_y;

        if (moving) begin
            n_m_valid = 1'b1;
            n_m_found = rd_found;
            n_m_x     = rd_found ? ram_rdata.x : '0;
            n_m_y     = rd_found ? ram_rdata.y : '0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc && (cmd == jfv_pkg::CMD_READ)) begin
                    n_resp_pend = 1'b1;
                    n_rd_inside = in_frame;
                end
                if (s_acc && (cmd == jfv_pkg::CMD_START)) begin
                    n_step      = dim_max >> 1;
                    n_col       = '0;
                    n_row       = '0;
                    n_nbx       = NB_LO;
                    n_nby       = NB_LO;
                    n_have      = 1'b0;
                    n_best_dist = '0;
                    n_best_site = '0;
                    if ((dim_max >> 1) != '0) begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                if (nx_ok && ny_ok) begin
                    n_state = S_READ;
                end else if (nb_last) begin
                    n_state = S_WRITE;
                end else if (r_nbx == NB_HI) begin
                    n_nbx = NB_LO;
                    n_nby = r_nby + 2'd1;
                end else begin
                    n_nbx = r_nbx + 2'd1;
                end
            end
            S_READ: begin
                n_dx = (col_d > sx_d) ? col_d - sx_d : sx_d - col_d;
                n_dy = (row_d > sy_d) ? row_d - sy_d : sy_d - row_d;
                if (ram_rdata.valid) begin
                    n_state = S_SQX;
                end else if (nb_last) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_ADDR;
                    if (r_nbx == NB_HI) begin
                        n_nbx = NB_LO;
                        n_nby = r_nby + 2'd1;
                    end else begin
                        n_nbx = r_nbx + 2'd1;
                    end
                end
                if (ram_rdata.valid) begin
                    n_best_site = r_best_site;
                end
            end
            S_SQX: begin
                n_acc   = sq;
                n_state = S_SQY;
            end
            S_SQY: begin
                // strict compare: earliest neighbour wins a tie
                if (!r_have || (nb_dist < r_best_dist)) begin
                    n_have      = 1'b1;
                    n_best_dist = nb_dist;
                    n_best_site = ram_rdata;
                end
                if (nb_last) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_ADDR;
                    if (r_nbx == NB_HI) begin
                        n_nbx = NB_LO;
                        n_nby = r_nby + 2'd1;
                    end else begin
                        n_nbx = r_nbx + 2'd1;
                    end
                end
            end
            S_WRITE: begin
                n_nbx       = NB_LO;
                n_nby       = NB_LO;
                n_have      = 1'b0;
                n_best_dist = '0;
                n_best_site = '0;
                n_state     = S_ADDR;
                if (!col_last) begin
                    n_col = r_col + XW'(1);
                end else begin
                    n_col = '0;
                    if (!row_last) begin
                        n_row = r_row + YW'(1);
                    end else begin
                        n_row  = '0;
                        n_step = step_half;
                        if (step_half == '0) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // RAM read data stays put in S_SQX/S_SQY since no read is issued there
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_nbx       <= NB_LO;
            r_nby       <= NB_LO;
            r_have      <= 1'b0;
            r_best_dist <= '0;
            r_best_site <= '0;
            r_resp_pend <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_col       <= n_col;
            r_row       <= n_row;
            r_nbx       <= n_nbx;
            r_nby       <= n_nby;
            r_have      <= n_have;
            r_best_dist <= n_best_dist;
            r_best_site <= n_best_site;
            r_resp_pend <= n_resp_pend;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_acc       <= n_acc;
        r_rd_inside <= n_rd_inside;
        r_m_found   <= n_m_found;
        r_m_x       <= n_m_x;
        r_m_y       <= n_m_y;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= jfv_pkg::DIM_RESET;
            r_height <= jfv_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == jfv_pkg::CFG_WIDTH) begin
                r_width <= i_cfg_wdata;
            end else begin
                r_height <= i_cfg_wdata;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_y, r_m_x};
    assign m_axis_tuser  = r_m_found;

    // ------------------------------------------------------------ checks
    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_step != '0))
        else $error("flood running with zero step");

    a_read_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (cmd == jfv_pkg::CMD_READ)) |=> r_resp_pend)
        else $error("read request lost its response");

    a_sqx_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQX) |-> ($past(r_state) == S_READ))
        else $error("squarer started without a site read");

    a_sqy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQY) |-> ($past(r_state) == S_SQX))
        else $error("distance sum without first square");

endmodule

[tb/sv/jfv_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// jfv_checker - nearest-site predictor and result checker
// Watches the request, result and configuration ports of the jump flooding
// engine, keeps its own site map, floods it on each start request and
// compares every read result with the oldest predicted nearest site.
// ============================================================================
module jfv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y, is_site
    input  logic [1:0]  s_axis_tuser,   // command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // site_x, site_y
    input  logic [0:0]  m_axis_tuser,   // found
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int MAP_COLS = 256;
    localparam int MAP_ROWS = 256;

    typedef struct packed {
        logic                       found;
        logic [jfv_pkg::COORD_W-1:0] x;
        logic [jfv_pkg::COORD_W-1:0] y;
    } t_read_result;

    jfv_pkg::t_site            site_map [0:MAP_COLS*MAP_ROWS-1];
    logic [jfv_pkg::REG_W-1:0] width_reg;
    logic [jfv_pkg::REG_W-1:0] height_reg;
    t_read_result              nearest_site_q [$];
    int                        mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    initial begin
        foreach (site_map[i]) site_map[i] = '0;
    end

    function automatic int dim_in_use(logic [jfv_pkg::REG_W-1:0] value, int limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // In-place jump flooding, raster scan, first nearest site wins a tie.
    function automatic void flood_site_map();
        int             w, h, step, ny, nx, sx, sy, ddx, ddy, sq_dist, best_dist;
        bit             have;
        jfv_pkg::t_site entry, best;
        w = dim_in_use(width_reg, MAP_COLS);
        h = dim_in_use(height_reg, MAP_ROWS);
        step = (w > h ? w : h) / 2;
        while (step > 0) begin
            for (int row = 0; row < h; row++) begin
                for (int col = 0; col < w; col++) begin
                    have      = 1'b0;
                    best_dist = 0;
                    best      = '0;
                    for (int oy = -1; oy <= 1; oy++) begin
                        for (int ox = -1; ox <= 1; ox++) begin
                            ny = row + oy * step;
                            nx = col + ox * step;
                            if (nx >= 0 && ny >= 0 && nx < w && ny < h) begin
                                entry = site_map[ny * MAP_COLS + nx];
                                if (entry.valid) begin
                                    sx      = entry.x;
                                    sy      = entry.y;
                                    ddx     = col > sx ? col - sx : sx - col;
                                    ddy     = row > sy ? row - sy : sy - row;
                                    sq_dist = ddx * ddx + ddy * ddy;
                                    if (!have || sq_dist < best_dist) begin
                                        have      = 1'b1;
                                        best_dist = sq_dist;
                                        best      = entry;
                                    end
                                end
                            end
                        end
                    end
                    site_map[row * MAP_COLS + col] = have ? best : '0;
                end
            end
            step = step / 2;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] checker: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        logic [jfv_pkg::COORD_W-1:0] px, py;
        bit                          in_frame;
        jfv_pkg::t_site              entry;
        t_read_result                want, got;
        if (!i_rst_n) begin
            width_reg  = jfv_pkg::DIM_RESET;
            height_reg = jfv_pkg::DIM_RESET;
            nearest_site_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                px       = s_axis_tdata[7:0];
                py       = s_axis_tdata[15:8];
                in_frame = px < dim_in_use(width_reg, MAP_COLS)
                        && py < dim_in_use(height_reg, MAP_ROWS);
                case (jfv_pkg::t_cmd'(s_axis_tuser))
                    jfv_pkg::CMD_LOAD: begin
                        if (in_frame)
                            site_map[py * MAP_COLS + px] =
                                s_axis_tdata[16] ? {1'b1, px, py} : '0;
                    end
                    jfv_pkg::CMD_START: flood_site_map();
                    jfv_pkg::CMD_READ: begin
                        entry = in_frame ? site_map[py * MAP_COLS + px] : '0;
                        want  = entry.valid ? {1'b1, entry.x, entry.y} : '0;
                        nearest_site_q = {nearest_site_q, want};
                    end
                    default: ;  // unknown command: dropped
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[15:8]};
                if (nearest_site_q.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: found %0b (%0d,%0d)",
                                              got.found, got.x, got.y));
                end else begin
                    want = nearest_site_q.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found got %b want %b",
                                                  got.found, want.found));
                    if (got.x !== want.x)
                        report_mismatch($sformatf("site_x got %0d want %0d", got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("site_y got %0d want %0d", got.y, want.y));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    jfv_pkg::CFG_WIDTH:  width_reg  = i_cfg_wdata;
                    jfv_pkg::CFG_HEIGHT: height_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        o_pending <= nearest_site_q.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb - top level testbench for the jump flooding Voronoi engine
// Loads whole frames of random site flags, floods them and reads back the
// nearest sites under random idling on both streams; a checker beside the
// engine predicts every read result and counts mismatches.
// ============================================================================
module tb;

    localparam int ITEMS    = 1250;    // requests that do real work
    localparam int MAP_COLS = 256;
    localparam int TAIL     = 64;      // drain cycles after the last result

    // command code the engine must drop without a result
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // pixel_x[7:0], pixel_y[15:8], is_site[16]
    logic [1:0]  s_axis_tuser  = '0;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // site_x[7:0], site_y[15:8]
    logic [0:0]  m_axis_tuser;         // found[0]
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = 1'b0;
    logic [8:0]  i_cfg_wdata   = '0;

    int fail_count;
    int pending;

    // stimulus-side view of the frame
    int frame_w     = 256;
    int frame_h     = 256;
    bit loaded_map [0:MAP_COLS*256-1];   // pixels written at least once
    int items_sent  = 0;
    int stall_pct   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    jump_flood_voronoi DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    jfv_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Result side back-pressure; stall_pct follows the idling schedule.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hard stop well beyond the slowest legal run (floods dominate).
    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // One request: random idle cycles first, then hold until accepted.
    task automatic send_request(input logic [1:0] cmd, input int x, input int y,
                                input bit site);
        bit in_frame;
        int idle_pct;
        in_frame = x < frame_w && y < frame_h;
        // idling schedule: sender light / receiver heavy, then swapped, then none
        if (items_sent < ITEMS / 3) begin
            idle_pct  = 20;
            stall_pct = 71;
        end else if (items_sent < 2 * ITEMS / 3) begin
            idle_pct  = 71;
            stall_pct = 20;
        end else begin
            idle_pct  = 0;
            stall_pct = 0;
        end
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, site, 8'(y), 8'(x)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == jfv_pkg::CMD_LOAD && in_frame)
            loaded_map[y * MAP_COLS + x] = 1'b1;
        // dropped requests don't count toward the item budget
        if (!(cmd == CMD_NONE || (cmd == jfv_pkg::CMD_LOAD && !in_frame)))
            items_sent++;
    endtask

    // Register write, only once the engine has gone quiet.
    task automatic write_reg(input logic addr, input logic [8:0] value);
        int dim;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);   // covers a trailing load or a late flag
        while (pending != 0) @(posedge i_clk);   // last read still waiting to leave
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dim = value == 0 ? 1 : (value > 256 ? 256 : int'(value));
        if (addr == jfv_pkg::CFG_WIDTH) frame_w = dim;
        else frame_h = dim;
    endtask

    // Noise: dropped commands, out-of-frame requests, reads of loaded pixels.
    task automatic send_noise();
        int         x, y;
        logic [1:0] cmd;
        case ($urandom_range(0, 2))
            0: send_request(CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 1));
            1: begin
                cmd = $urandom_range(0, 1) ? jfv_pkg::CMD_LOAD : jfv_pkg::CMD_READ;
                x   = $urandom_range(0, 255);
                y   = $urandom_range(0, 255);
                if (frame_w < 256) x = $urandom_range(frame_w, 255);
                else if (frame_h < 256) y = $urandom_range(frame_h, 255);
                else cmd = CMD_NONE;   // full frame: nothing lies outside
                send_request(cmd, x, y, $urandom_range(0, 1));
            end
            default: begin
                x = $urandom_range(0, frame_w - 1);
                y = $urandom_range(0, frame_h - 1);
                // never read a pixel that was never written
                if (loaded_map[y * MAP_COLS + x]) send_request(jfv_pkg::CMD_READ, x, y, 1'b0);
                else send_request(CMD_NONE, x, y, 1'b1);
            end
        endcase
    endtask

    initial begin
        int w_val, h_val, density, phase, tmp;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: reset frame 256x256, corner pixels, no flood ---
        send_request(jfv_pkg::CMD_LOAD,  0,   0,   1'b1);
        send_request(jfv_pkg::CMD_LOAD,  255, 255, 1'b1);
        send_request(jfv_pkg::CMD_LOAD,  255, 0,   1'b0);
        send_request(jfv_pkg::CMD_LOAD,  0,   255, 1'b1);
        send_request(CMD_NONE,           255, 255, 1'b1);   // unknown command, dropped
        send_request(jfv_pkg::CMD_READ,  0,   0,   1'b0);
        send_request(jfv_pkg::CMD_READ,  255, 255, 1'b0);
        send_request(jfv_pkg::CMD_READ,  255, 0,   1'b0);
        send_request(jfv_pkg::CMD_READ,  0,   255, 1'b0);

        // --- directed: 1x1 frame, empty then one site ---
        write_reg(jfv_pkg::CFG_WIDTH,  9'd1);
        write_reg(jfv_pkg::CFG_HEIGHT, 9'd1);
        send_request(jfv_pkg::CMD_LOAD,  0,   0,   1'b0);
        send_request(jfv_pkg::CMD_START, 0,   0,   1'b0);   // empty frame
        send_request(jfv_pkg::CMD_READ,  0,   0,   1'b0);
        send_request(jfv_pkg::CMD_LOAD,  0,   0,   1'b1);
        send_request(jfv_pkg::CMD_START, 0,   0,   1'b0);   // step is zero: no pass
        send_request(jfv_pkg::CMD_READ,  0,   0,   1'b0);
        send_request(jfv_pkg::CMD_LOAD,  200, 100, 1'b1);   // outside: dropped
        send_request(jfv_pkg::CMD_READ,  200, 100, 1'b0);   // outside: zero result
        send_request(jfv_pkg::CMD_READ,  255, 255, 1'b0);   // loaded earlier, now outside

        // --- random phases: configure, load whole frame, flood, read back ---
        phase = 0;
        while (items_sent < ITEMS) begin
            if (phase == 0) begin
                w_val = 0;     // counts as 1
                h_val = 511;   // counts as 256
            end else if (phase == 1) begin
                w_val = 256;
                h_val = 0;
            end else if ($urandom_range(0, 5) == 0) begin
                // thin strip
                w_val = $urandom_range(13, 48);
                h_val = $urandom_range(0, 2);
                if ($urandom_range(0, 1)) begin
                    tmp   = w_val;
                    w_val = h_val;
                    h_val = tmp;
                end
            end else begin
                w_val = $urandom_range(0, 12);
                h_val = $urandom_range(0, 12);
            end
            write_reg(jfv_pkg::CFG_WIDTH,  9'(w_val));
            write_reg(jfv_pkg::CFG_HEIGHT, 9'(h_val));

            case ($urandom_range(0, 9))
                0:       density = 0;     // empty frame
                1:       density = 100;   // every pixel a site
                default: density = $urandom_range(2, 35);
            endcase

            // every pixel in use gets loaded before the flood
            for (int y = 0; y < frame_h; y++) begin
                for (int x = 0; x < frame_w; x++) begin
                    if ($urandom_range(0, 15) == 0) send_noise();
                    send_request(jfv_pkg::CMD_LOAD, x, y, $urandom_range(0, 99) < density);
                end
            end

            send_request(jfv_pkg::CMD_START, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 1));
            // sometimes touch up a few pixels and flood the labeled map again
            if (frame_w * frame_h <= 144 && $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_request(jfv_pkg::CMD_LOAD, $urandom_range(0, frame_w - 1),
                                 $urandom_range(0, frame_h - 1), $urandom_range(0, 1));
                send_request(jfv_pkg::CMD_START, 0, 0, 1'b0);
            end

            // read back: whole frame when small, else a random sample
            if (frame_w * frame_h <= 24) begin
                for (int y = 0; y < frame_h; y++) begin
                    for (int x = 0; x < frame_w; x++) begin
                        if ($urandom_range(0, 7) == 0) send_noise();
                        send_request(jfv_pkg::CMD_READ, x, y, $urandom_range(0, 1));
                    end
                end
            end else begin
                repeat (24) begin
                    if ($urandom_range(0, 7) == 0) send_noise();
                    send_request(jfv_pkg::CMD_READ, $urandom_range(0, frame_w - 1),
                                 $urandom_range(0, frame_h - 1), $urandom_range(0, 1));
                end
            end
            phase++;
        end

        // --- drain and verdict ---
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[jump_flood_voronoi.f]
src/jfv_pkg.sv
src/jfv_site_ram.sv
src/jump_flood_voronoi.sv
tb/sv/jfv_checker.sv
tb/sv/tb.sv
